@@ hdl/gm_pkg.sv @@
`default_nettype none

package gm_pkg;

    localparam int VALUE_W     = 32;
    localparam int GSIZE_W     = 7;
    localparam int SUM_W       = 32;
    localparam int FRAC_BITS   = 16;
    localparam int QUOT_W      = SUM_W + 1;
    localparam int MAX_GROUP_DEF = 16;

    typedef logic [FRAC_BITS-1:0][VALUE_W-1:0] root_tab_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOG  = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_EXP  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    // integer square root, bitwise
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x    = x_in;
        res  = '0;
        for (int i = 0; i < 32; i++)
        begin
            bitv = 64'd1 << (62 - 2 * i);
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // entry k-1 holds 2^(2^-k) in Q1.31
    function automatic root_tab_t calc_roots();
        root_tab_t   tab;
        logic [63:0] root;
        root = 64'd1 << 32;
        for (int k = 0; k < FRAC_BITS; k++)
        begin
            root   = isqrt64(root << 31);
            tab[k] = root[VALUE_W-1:0];
        end
        return tab;
    endfunction

    localparam root_tab_t ROOTS = calc_roots();

endpackage

`default_nettype wire

@@ hdl/gm_div.sv @@
`default_nettype none

module gm_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [gm_pkg::SUM_W-1:0]    dividend,
    input  wire logic [gm_pkg::GSIZE_W-1:0]         divisor,
    output logic                                    done,
    output logic signed [gm_pkg::QUOT_W-1:0]        quot
);

    localparam int CNT_W = $clog2(gm_pkg::SUM_W);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [gm_pkg::SUM_W-1:0]       dvd_reg, dvd_next;
    logic [gm_pkg::SUM_W-1:0]       qb_reg, qb_next;
    logic [gm_pkg::GSIZE_W:0]       rem_reg, rem_next;
    logic [gm_pkg::GSIZE_W-1:0]     den_reg, den_next;
    logic                           neg_reg, neg_next;
    logic signed [gm_pkg::QUOT_W-1:0] quot_reg, quot_next;

    logic [gm_pkg::GSIZE_W+1:0]     trial;
    logic [gm_pkg::GSIZE_W+1:0]     diff;
    logic                           fits;
    logic [gm_pkg::SUM_W-1:0]       qb_new;
    logic [gm_pkg::GSIZE_W:0]       rem_new;
    logic [gm_pkg::QUOT_W-1:0]      mag;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        qb_next   = qb_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;

        trial   = {rem_reg, dvd_reg[gm_pkg::SUM_W-1]};
        diff    = trial - {2'b00, den_reg};
        fits    = trial >= {2'b00, den_reg};
        rem_new = fits ? diff[gm_pkg::GSIZE_W:0] : trial[gm_pkg::GSIZE_W:0];
        qb_new  = {qb_reg[gm_pkg::SUM_W-2:0], fits};
        mag     = {1'b0, qb_new} + gm_pkg::QUOT_W'(neg_reg && rem_new != '0);

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[gm_pkg::SUM_W-1];
            dvd_next  = dividend[gm_pkg::SUM_W-1] ? gm_pkg::SUM_W'(-dividend)
                                                  : gm_pkg::SUM_W'(dividend);
            qb_next   = '0;
            rem_next  = '0;
            den_next  = (divisor == '0) ? gm_pkg::GSIZE_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[gm_pkg::SUM_W-2:0], 1'b0};
            qb_next  = qb_new;
            rem_next = rem_new;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(gm_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quot_next = neg_reg ? gm_pkg::QUOT_W'(-mag) : mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        qb_reg   <= qb_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

@@ hdl/geometric_mean_log_domain.sv @@
// Geometric mean of groups of unsigned Q17.15 values, computed in the log domain.
// Input stream s_*: tdata = value, tlast marks the final value of a group.
// Output stream m_*: tdata = mean (Q17.15), tuser = zero_seen; one transfer per group.
// cfg_we/cfg_wdata write group_size (0 acts as 1); write only while idle.
// The log and exp steps share one 32x32 multiplier: 16 squaring steps for the
// log2 of a value, 16 product steps for the exp2 at group end.
// A value passes ST_LOG and ST_ACC (a zero value only ST_ACC) before s_tready returns.
// A last value then passes the bit-serial signed divider (ST_DIV), the exp steps
// (ST_EXP) and ST_FIN, which loads the output register; a group with a zero skips to ST_FIN.
// The output register holds the result until m_tready; the next group's values
// are taken meanwhile, and only the following group end waits for it.
// Reset clears the log sum, the zero flag, the output valid, and sets
// group_size to MAX_GROUP.
`default_nettype none

module geometric_mean_log_domain #(
    parameter int MAX_GROUP = gm_pkg::MAX_GROUP_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [gm_pkg::VALUE_W-1:0]     s_tdata,   // [31:0] value
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [gm_pkg::VALUE_W-1:0]          m_tdata,   // [31:0] mean
    output logic                                m_tuser,   // [0] zero_seen
    input  wire logic                           cfg_we,
    input  wire logic [gm_pkg::GSIZE_W-1:0]     cfg_wdata
);

    localparam int VW    = gm_pkg::VALUE_W;
    localparam int SW    = gm_pkg::SUM_W;
    localparam int FB    = gm_pkg::FRAC_BITS;
    localparam int QW    = gm_pkg::QUOT_W;
    localparam int CNT_W = $clog2(FB);
    localparam int LG_W  = 6 + FB;

    gm_pkg::state_t              state_reg, state_next;
    logic [gm_pkg::GSIZE_W-1:0]  gsize_reg;
    logic signed [SW-1:0]        sum_reg, sum_next;
    logic                        zflag_reg, zflag_next;
    logic                        last_reg, last_next;
    logic                        vzero_reg, vzero_next;
    logic [VW-1:0]               m_reg, m_next;
    logic [FB-1:0]               frac_reg, frac_next;
    logic signed [5:0]           ip_reg, ip_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic signed [QW-1:0]        q_reg, q_next;
    logic                        ovalid_reg, ovalid_next;
    logic [VW-1:0]               omean_reg, omean_next;
    logic                        ozero_reg, ozero_next;

    logic [4:0]                  msb;
    logic [VW-1:0]               opb;
    logic [2*VW-1:0]             prod;
    logic                        div_start, div_done;
    logic signed [QW-1:0]        div_q;
    logic signed [LG_W-1:0]      lg;
    logic signed [SW+1:0]        sum_ext;
    logic signed [QW-FB-1:0]     qi;
    logic signed [QW-FB:0]       amt;
    logic [VW-1:0]               mean_c;
    logic                        in_acc;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < VW; i++)
        begin
            if (s_tdata[i])
            begin
                msb = 5'(i);
            end
        end
    end

    assign opb  = (state_reg == gm_pkg::ST_LOG) ? m_reg : gm_pkg::ROOTS[cnt_reg];
    assign prod = m_reg * opb;

    assign lg      = {ip_reg, frac_reg};
    assign sum_ext = (SW+2)'(sum_reg) + (SW+2)'(lg);

    assign qi  = q_reg[QW-1:FB];
    assign amt = (QW-FB+1)'(16) - (QW-FB+1)'(qi);

    always_comb
    begin
        if (zflag_reg)
        begin
            mean_c = '0;
        end
        else if (amt < 0)
        begin
            mean_c = '1;
        end
        else if (amt >= (QW-FB+1)'(VW))
        begin
            mean_c = '0;
        end
        else
        begin
            mean_c = m_reg >> amt[4:0];
        end
    end

    assign in_acc = s_tvalid && s_tready;

    always_comb
    begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        zflag_next  = zflag_reg;
        last_next   = last_reg;
        vzero_next  = vzero_reg;
        m_next      = m_reg;
        frac_next   = frac_reg;
        ip_next     = ip_reg;
        cnt_next    = cnt_reg;
        q_next      = q_reg;
        ovalid_next = ovalid_reg && !m_tready;
        omean_next  = omean_reg;
        ozero_next  = ozero_reg;
        div_start   = 1'b0;

        case (state_reg)
            gm_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    last_next  = s_tlast;
                    vzero_next = (s_tdata == '0);
                    m_next     = s_tdata << (5'd31 - msb);
                    ip_next    = 6'(msb) - 6'sd15;
                    frac_next  = '0;
                    cnt_next   = '0;
                    if (s_tdata == '0)
                    begin
                        zflag_next = 1'b1;
                        state_next = gm_pkg::ST_ACC;
                    end
                    else
                    begin
                        state_next = gm_pkg::ST_LOG;
                    end
                end
            end
            gm_pkg::ST_LOG:
            begin
                frac_next = {frac_reg[FB-2:0], prod[2*VW-1]};
                m_next    = prod[2*VW-1] ? prod[2*VW-1:VW] : prod[2*VW-2:VW-1];
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FB - 1))
                begin
                    state_next = gm_pkg::ST_ACC;
                end
            end
            gm_pkg::ST_ACC:
            begin
                if (!vzero_reg)
                begin
                    if (sum_ext > (SW+2)'(32'sh7FFFFFFF))
                    begin
                        sum_next = 32'sh7FFFFFFF;
                    end
                    else if (sum_ext < -(SW+2)'(34'sh080000000))
                    begin
                        sum_next = 32'sh80000000;
                    end
                    else
                    begin
                        sum_next = sum_ext[SW-1:0];
                    end
                end
                if (!last_reg)
                begin
                    state_next = gm_pkg::ST_IDLE;
                end
                else if (zflag_reg)
                begin
                    state_next = gm_pkg::ST_FIN;
                end
                else
                begin
                    state_next = gm_pkg::ST_DIV;
                end
            end
            gm_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    q_next     = div_q;
                    m_next     = VW'(1) << (VW - 1);
                    cnt_next   = '0;
                    state_next = gm_pkg::ST_EXP;
                end
            end
            gm_pkg::ST_EXP:
            begin
                if (q_reg[FB-1-cnt_reg])
                begin
                    m_next = prod[2*VW-2:VW-1];
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FB - 1))
                begin
                    state_next = gm_pkg::ST_FIN;
                end
            end
            gm_pkg::ST_FIN:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    omean_next  = mean_c;
                    ozero_next  = zflag_reg;
                    sum_next    = '0;
                    zflag_next  = 1'b0;
                    state_next  = gm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gm_pkg::ST_IDLE;
            end
        endcase

        if (state_reg == gm_pkg::ST_ACC && last_reg && !zflag_reg)
        begin
            div_start = 1'b1;
        end
    end

    gm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (gsize_reg),
        .done     (div_done),
        .quot     (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gm_pkg::ST_IDLE;
            gsize_reg  <= gm_pkg::GSIZE_W'(MAX_GROUP);
            sum_reg    <= '0;
            zflag_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            zflag_reg  <= zflag_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
            if (cfg_we)
            begin
                gsize_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        vzero_reg <= vzero_next;
        m_reg     <= m_next;
        frac_reg  <= frac_next;
        ip_reg    <= ip_next;
        q_reg     <= q_next;
        omean_reg <= omean_next;
        ozero_reg <= ozero_next;
    end

    assign s_tready = (state_reg == gm_pkg::ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = omean_reg;
    assign m_tuser  = ozero_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_geometric_mean_log_domain.sv @@
`timescale 1ns / 100ps
`default_nettype none

module tb_geometric_mean_log_domain;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_ITEMS   = 800;

    typedef struct packed {
        logic [31:0] mean;
        logic        zero_seen;
    } gm_result_t;

    typedef struct {
        logic [31:0] value;
        logic        last;
        logic        check_typed;
        logic [31:0] typed_mean;
        logic        typed_zero;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [gm_pkg::VALUE_W-1:0]     s_tdata;    // [31:0] value
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [gm_pkg::VALUE_W-1:0]     m_tdata;    // [31:0] mean
    logic                           m_tuser;    // [0] zero_seen
    logic                           cfg_we;
    logic [gm_pkg::GSIZE_W-1:0]     cfg_wdata;

    geometric_mean_log_domain u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [6:0]        pred_group_size;
    logic signed [31:0] pred_log_sum;
    logic              pred_zero_flag;

    gm_result_t        mean_queue[$];
    int                error_count;
    int                idle_count;
    int                send_idle_pct;
    int                recv_idle_pct;
    logic              sim_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic logic signed [63:0] log2_fixed(input logic [31:0] v);
        int          p;
        logic [63:0] m;
        logic [63:0] sq;
        logic [15:0] frac;
        p = 31;
        while (p > 0 && v[p] == 1'b0)
            p--;
        m = {32'd0, v << (31 - p)};
        frac = '0;
        for (int k = 0; k < 16; k++)
        begin
            sq = (m * m) >> 31;
            frac = frac << 1;
            if (sq >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                m = sq >> 1;
            end
            else
            begin
                m = sq;
            end
        end
        return 64'(signed'(p - 15)) * 65536 + $signed({48'd0, frac});
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x = x_in;
        res = '0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] exp2_fixed(input logic signed [63:0] q);
        logic [15:0]        f;
        logic signed [63:0] ip;
        logic signed [63:0] sh;
        logic [63:0]        root;
        logic [63:0]        acc;
        f = q[15:0];
        ip = (q - $signed({48'd0, f})) / 65536;
        root = 64'd1 << 32;
        acc = 64'd1 << 31;
        for (int k = 1; k <= 16; k++)
        begin
            root = int_sqrt(root << 31);
            if (f[16 - k])
                acc = (acc * root) >> 31;
        end
        sh = ip - 16;
        if (sh > 0)
            return 32'hFFFF_FFFF;
        if (sh == 0)
            return (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
        if (-sh >= 64)
            return 32'd0;
        return 32'(acc >> (-sh));
    endfunction

    // returns 1 and the result when the item closes a group
    function automatic logic predict_group(input logic [31:0] v, input logic last,
                                           output gm_result_t res);
        logic signed [63:0] s;
        logic signed [63:0] n;
        logic signed [63:0] q;
        res = '0;
        if (v == 0)
            pred_zero_flag = 1'b1;
        else
        begin
            s = 64'(pred_log_sum) + log2_fixed(v);
            if (s > 64'sd2147483647)
                s = 64'sd2147483647;
            if (s < -64'sd2147483648)
                s = -64'sd2147483648;
            pred_log_sum = s[31:0];
        end
        if (!last)
            return 1'b0;
        if (!pred_zero_flag)
        begin
            n = (pred_group_size == 0) ? 64'sd1 : $signed({57'd0, pred_group_size});
            s = 64'(pred_log_sum);
            q = (s >= 0) ? s / n : -((-s + n - 1) / n);
            res.mean = exp2_fixed(q);
        end
        res.zero_seen = pred_zero_flag;
        pred_log_sum = '0;
        pred_zero_flag = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // s_tvalid stays high after a transfer until the next call or a drain
    task automatic send_value(input logic [31:0] v, input logic last);
        gm_result_t res;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (predict_group(v, last, res))
            mean_queue.insert(mean_queue.size(), res);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (mean_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_group_size(input logic [6:0] n);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(negedge clk);
        cfg_we    <= 1'b0;
        pred_group_size = n;
    endtask

    // sends one group with mostly small-magnitude values from 0 to 4.0 (Q17.15)
    task automatic send_random_group(input int len);
        logic [31:0] v;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(9))
                0:       v = $urandom;
                1:       v = 32'd1 << $urandom_range(31);
                2:       v = ($urandom_range(30) == 0) ? 32'd0 : $urandom_range(255);
                3:       v = 32'hFFFF_FFFF - $urandom_range(3);
                default: v = 32'h8000 + $urandom_range(32'h20000) - 32'h8000;
            endcase
            send_value(v, i == len - 1);
        end
    endtask

    // receiver and checker
    initial
    begin
        gm_result_t want;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (mean_queue.size() == 0)
                    report_mismatch("unexpected transfer", m_tdata, 32'd0);
                else
                begin
                    want = mean_queue.pop_front();
                    if (m_tdata !== want.mean)
                        report_mismatch("mean", m_tdata, want.mean);
                    if (m_tuser !== want.zero_seen)
                        report_mismatch("zero_seen", m_tuser, want.zero_seen);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        idle_count = 0;
        sim_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= WATCHDOG_LIMIT && !sim_done)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    stim_row_t directed_rows[] = '{
        '{32'h0000_8000, 1'b1, 1'b1, 32'h0000_8000, 1'b0},  // 1.0 alone
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1},  // zero value
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0,         1'b0},
        '{32'h0000_0001, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h0000_0001, 1'b1, 1'b0, 32'h0,         1'b0},
        '{32'h0000_8000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000, 1'b1},  // zero mid-group
        '{32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h0001_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'h5555_5555, 1'b0, 1'b0, 32'h0,         1'b0},
        '{32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0,         1'b0}
    };

    initial
    begin
        gm_result_t res;
        error_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pred_group_size = 7'(gm_pkg::MAX_GROUP_DEF);
        pred_log_sum = '0;
        pred_zero_flag = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_group_size(7'd1);
        foreach (directed_rows[i])
        begin
            send_value(directed_rows[i].value, directed_rows[i].last);
            if (directed_rows[i].check_typed && directed_rows[i].last)
            begin
                res = mean_queue[$];
                if (res.mean !== directed_rows[i].typed_mean
                    || res.zero_seen !== directed_rows[i].typed_zero)
                    report_mismatch("directed row", res.mean, directed_rows[i].typed_mean);
            end
        end
        // overflowing mean at size zero, mean of tiny values at size 127
        write_group_size(7'd0);
        for (int i = 0; i < 3; i++)
            send_value(32'hFFFF_FFFF, i == 2);
        write_group_size(7'd127);
        for (int i = 0; i < 4; i++)
            send_value(32'd1, i == 3);
        write_group_size(7'd64);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 63 : 0;
            recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 23 : 0;
            write_group_size(7'($urandom_range(1, 64)));
            for (int n = 0; n < RANDOM_ITEMS / 3; )
            begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(17, 64)
                                              : $urandom_range(1, 6);
                send_random_group(len);
                n += len;
                if ($urandom_range(15) == 0)
                    wait_drained();
                else if ($urandom_range(10) == 0)
                    write_group_size(7'($urandom_range(127)));
            end
        end

        wait_drained();
        sim_done = 1'b1;
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/gm_pkg.sv
hdl/gm_div.sv
hdl/geometric_mean_log_domain.sv
tb/sv/tb_geometric_mean_log_domain.sv
